// ===== sv/sliding_window_mean_percentile_unit_defines.svh =====
// Assertion macros shared by the sliding window statistics block
`ifndef SLIDING_WINDOW_MEAN_PERCENTILE_UNIT_DEFINES_SVH
`define SLIDING_WINDOW_MEAN_PERCENTILE_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define SWMP_ASSERT_NEVER(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);
`define SWMP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);
`else
`define SWMP_ASSERT_NEVER(lbl, cond, msg)
`define SWMP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== sv/swmp_pkg.sv =====
// Shared widths, constants and types of the sliding window statistics block
package swmp_pkg;
   localparam int WINDOW_DEPTH_DEFAULT = 256;
   localparam int SAMPLE_W = 32;
   localparam int FRAC_W = 17;
   localparam int HELD_W = 9;
   localparam int T_W = 16;
   localparam int PADDR_W = 3;
   localparam int PDATA_W = 32;
   localparam logic [FRAC_W-1:0] Q16_ONE = 17'h10000;
   localparam logic [FRAC_W-1:0] FRAC_RESET = 17'h08000;
   localparam logic REG_FRACTION = 1'b0;

   typedef struct packed {
      logic                remove;
      logic                insert;
      logic [SAMPLE_W-1:0] key;
   } cell_cmd_type;
endpackage

// ===== sv/swmp_req_if.sv =====
// Sample channel interface
interface swmp_req_if;
   logic                          valid;
   logic                          ready;
   logic [swmp_pkg::SAMPLE_W-1:0] sample_value;
   modport source (output valid, output sample_value, input ready);
   modport sink (input valid, input sample_value, output ready);
endinterface

// ===== sv/swmp_rsp_if.sv =====
// Result channel interface
interface swmp_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [swmp_pkg::SAMPLE_W-1:0] window_mean;
   logic [swmp_pkg::SAMPLE_W-1:0] window_percentile;
   logic [swmp_pkg::HELD_W-1:0]   held_count;
   modport source (output valid, output window_mean, output window_percentile,
                   output held_count, input ready);
   modport sink (input valid, input window_mean, input window_percentile,
                 input held_count, output ready);
endinterface

// ===== sv/sliding_window_mean_percentile_unit.sv =====
// Sliding window mean and percentile of latency samples: top level
// Each sample beat pushes a value into a window of the last WINDOW_DEPTH samples and
// returns one result beat: the truncated mean, an interpolated percentile at the
// fraction in register 0 (unsigned Q16, 65536 is the maximum, above that the
// percentile reads 0) and the number of samples held. The window is kept sorted in
// a chain of cells; a push first drops the oldest sample (read back from a ring
// memory) and then inserts the new one. The mean comes from a restoring divider
// that retires one quotient bit per cycle over the 32+log2(WINDOW_DEPTH) bit
// running total, and this divider sets the pace: the output register loads after
// the remove, insert and divide states, and no new sample is accepted until the
// result has been loaded. A finished result holds until the previous one has left
// the output register; the next sample is taken while a result waits there.
// No clearing pass is needed after reset.
`include "sliding_window_mean_percentile_unit_defines.svh"
module sliding_window_mean_percentile_unit #(
   parameter int WINDOW_DEPTH = swmp_pkg::WINDOW_DEPTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   swmp_req_if.sink                     req_bus,
   swmp_rsp_if.source                   rsp_bus,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [swmp_pkg::PADDR_W-1:0] paddr,
   input  logic [swmp_pkg::PDATA_W-1:0] pwdata,
   output logic [swmp_pkg::PDATA_W-1:0] prdata,
   output logic                         pready
);
   localparam int SW = swmp_pkg::SAMPLE_W;
   localparam int FW = swmp_pkg::FRAC_W;
   localparam int TW = swmp_pkg::T_W;
   localparam int HW = swmp_pkg::HELD_W;
   localparam int IDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
   localparam int TOTAL_W = SW + $clog2(WINDOW_DEPTH);
   localparam int DIV_CW = $clog2(TOTAL_W);
   localparam int PROD_W = FW + CNT_W;
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(WINDOW_DEPTH);
   localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(WINDOW_DEPTH - 1);
   localparam logic [DIV_CW-1:0] DIV_LAST = DIV_CW'(TOTAL_W - 1);
   localparam logic [DIV_CW-1:0] STEP_SEL = DIV_CW'(0);
   localparam logic [DIV_CW-1:0] STEP_DIFF = DIV_CW'(1);
   localparam logic [DIV_CW-1:0] STEP_MUL = DIV_CW'(2);
   localparam logic [DIV_CW-1:0] STEP_SUM = DIV_CW'(3);

   typedef enum logic [2:0] {
      S_IDLE, S_REMOVE, S_INSERT, S_DIVIDE, S_PUSH
   } state_type;

   state_type                 state_ff;
   logic [SW-1:0]             ring [WINDOW_DEPTH];
   logic [SW-1:0]             sample_ff;
   logic [SW-1:0]             old_ff;
   logic                      full_old_ff;
   logic [IDX_W-1:0]          pos_ff;
   logic [CNT_W-1:0]          fill_ff;
   logic [TOTAL_W-1:0]        total_ff;
   logic [FW-1:0]             frac_ff;
   logic [PROD_W-1:0]         idx_ff;
   logic [TOTAL_W-1:0]        quo_ff;
   logic [CNT_W-1:0]          rem_ff;
   logic [DIV_CW-1:0]         step_ff;
   logic [SW-1:0]             a_ff;
   logic [SW-1:0]             b_ff;
   logic [SW-1:0]             diff_ff;
   logic [SW+TW-1:0]          prod_ff;
   logic [SW-1:0]             pct_ff;
   logic                      rsp_valid_ff;
   logic [SW-1:0]             mean_ff;
   logic [SW-1:0]             pct_out_ff;
   logic [HW-1:0]             held_out_ff;

   swmp_pkg::cell_cmd_type    cmd;
   logic [SW-1:0]             cell_val [WINDOW_DEPTH];
   logic [WINDOW_DEPTH-1:0]   cell_valid;
   logic [WINDOW_DEPTH-1:0]   cell_le;
   logic [WINDOW_DEPTH-1:0]   cell_gt;

   logic                      req_take;
   logic                      csr_write;
   logic                      push_fire;
   logic [CNT_W:0]            div_shift;
   logic [IDX_W-1:0]          lo;
   logic [TW-1:0]             t_frac;
   logic [IDX_W:0]            hi_wide;
   logic [IDX_W-1:0]          hi;
   logic [HW+CNT_W-1:0]       held_wide;
   logic [PROD_W-1:0]         fill_minus_one;

   // configuration port: one register, always ready
   assign pready = 1'b1;
   assign csr_write = psel && penable && pwrite && (paddr[2] == swmp_pkg::REG_FRACTION);
   assign prdata = (paddr[2] == swmp_pkg::REG_FRACTION) ?
                   swmp_pkg::PDATA_W'(frac_ff) : '0;

   assign req_take = req_bus.valid && req_bus.ready;
   assign req_bus.ready = (state_ff == S_IDLE);

   // load the output register once it is free or being freed this cycle
   assign push_fire = (state_ff == S_PUSH) && (!rsp_valid_ff || rsp_bus.ready);

   // drop takes the oldest value as key, insert the new sample
   assign cmd.remove = (state_ff == S_REMOVE) && full_old_ff;
   assign cmd.insert = (state_ff == S_INSERT);
   assign cmd.key = (state_ff == S_REMOVE) ? old_ff : sample_ff;

   for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
      logic          l_le;
      logic          l_valid;
      logic [SW-1:0] l_val;
      logic          r_gt;
      logic          r_valid;
      logic [SW-1:0] r_val;
      if (i == 0) begin : g_first
         assign l_le = 1'b1;
         assign l_valid = 1'b0;
         assign l_val = '0;
      end else begin : g_mid_l
         assign l_le = cell_le[i-1];
         assign l_valid = cell_valid[i-1];
         assign l_val = cell_val[i-1];
      end
      if (i == WINDOW_DEPTH - 1) begin : g_last
         assign r_gt = 1'b1;
         assign r_valid = 1'b0;
         assign r_val = '0;
      end else begin : g_mid_r
         assign r_gt = cell_gt[i+1];
         assign r_valid = cell_valid[i+1];
         assign r_val = cell_val[i+1];
      end
      swmp_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .left_le     (l_le),
         .left_valid  (l_valid),
         .left_val    (l_val),
         .right_gt    (r_gt),
         .right_valid (r_valid),
         .right_val   (r_val),
         .val         (cell_val[i]),
         .valid       (cell_valid[i]),
         .le          (cell_le[i]),
         .gt          (cell_gt[i])
      );
   end

   // order statistic picks: upper one only matters with a nonzero fraction
   assign lo = idx_ff[TW +: IDX_W];
   assign t_frac = idx_ff[TW-1:0];
   assign hi_wide = {1'b0, lo} + (IDX_W + 1)'(1);
   assign hi = (t_frac == '0) ? lo : hi_wide[IDX_W-1:0];
   assign div_shift = {rem_ff, quo_ff[TOTAL_W-1]};
   assign held_wide = {{HW{1'b0}}, fill_ff};
   assign fill_minus_one = PROD_W'(fill_ff) - PROD_W'(1);

   // ring memory of raw samples, read for the value leaving the window
   always_ff @(posedge clock) begin
      if (req_take) begin
         old_ff <= ring[pos_ff];
      end
      if (state_ff == S_REMOVE) begin
         ring[pos_ff] <= sample_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pos_ff <= '0;
         fill_ff <= '0;
         total_ff <= '0;
         frac_ff <= swmp_pkg::FRAC_RESET;
         rsp_valid_ff <= 1'b0;
         full_old_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         if (csr_write) begin
            frac_ff <= pwdata[FW-1:0];
         end
         if (push_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_take) begin
                  sample_ff <= req_bus.sample_value;
                  full_old_ff <= (fill_ff == DEPTH_C);
                  if (fill_ff != DEPTH_C) begin
                     fill_ff <= fill_ff + CNT_W'(1);
                  end
                  state_ff <= S_REMOVE;
               end
            end
            S_REMOVE: begin
               // drop the oldest sample from total and chain, advance ring
               if (full_old_ff) begin
                  total_ff <= total_ff - TOTAL_W'(old_ff);
               end
               pos_ff <= (pos_ff == LAST_POS) ? '0 : pos_ff + IDX_W'(1);
               state_ff <= S_INSERT;
            end
            S_INSERT: begin
               total_ff <= total_ff + TOTAL_W'(sample_ff);
               quo_ff <= total_ff + TOTAL_W'(sample_ff);
               rem_ff <= '0;
               step_ff <= '0;
               idx_ff <= PROD_W'(frac_ff) * fill_minus_one;
               state_ff <= S_DIVIDE;
            end
            S_DIVIDE: begin
               // one quotient bit per cycle
               if (div_shift >= {1'b0, fill_ff}) begin
                  rem_ff <= CNT_W'(div_shift - {1'b0, fill_ff});
                  quo_ff <= {quo_ff[TOTAL_W-2:0], 1'b1};
               end else begin
                  rem_ff <= div_shift[CNT_W-1:0];
                  quo_ff <= {quo_ff[TOTAL_W-2:0], 1'b0};
               end
               // percentile runs alongside in its select, diff, multiply and sum steps
               if (step_ff == STEP_SEL) begin
                  a_ff <= cell_val[lo];
                  b_ff <= cell_val[hi];
               end
               if (step_ff == STEP_DIFF) begin
                  diff_ff <= b_ff - a_ff;
               end
               if (step_ff == STEP_MUL) begin
                  prod_ff <= diff_ff * t_frac;
               end
               if (step_ff == STEP_SUM) begin
                  pct_ff <= (frac_ff > swmp_pkg::Q16_ONE) ? '0 :
                            a_ff + prod_ff[SW+TW-1:TW];
               end
               step_ff <= step_ff + DIV_CW'(1);
               if (step_ff == DIV_LAST) begin
                  state_ff <= S_PUSH;
               end
            end
            S_PUSH: begin
               // hold until the output register is free
               if (push_fire) begin
                  mean_ff <= quo_ff[SW-1:0];
                  pct_out_ff <= pct_ff;
                  held_out_ff <= held_wide[HW-1:0];
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.window_mean = mean_ff;
   assign rsp_bus.window_percentile = pct_out_ff;
   assign rsp_bus.held_count = held_out_ff;

   `SWMP_ASSERT_NEVER(a_fill_bound, fill_ff > DEPTH_C, "fill level beyond window depth")
   `SWMP_ASSERT_NEVER(a_chain_count, (state_ff == S_IDLE) && ($countones(cell_valid) != int'(fill_ff)), "chain cell count differs from fill level")
   `SWMP_ASSERT_NEVER(a_empty_total, (fill_ff == '0) && (total_ff != '0), "running total nonzero with empty window")
   `SWMP_ASSERT_NEXT(a_accept_seq, req_take, state_ff == S_REMOVE, "accepted beat did not start removal")
endmodule

// ===== sv/swmp_cell.sv =====
// One cell of the sorted window chain: insert and delete by neighbor shifts
module swmp_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  swmp_pkg::cell_cmd_type        cmd,
   input  logic                          left_le,
   input  logic                          left_valid,
   input  logic [swmp_pkg::SAMPLE_W-1:0] left_val,
   input  logic                          right_gt,
   input  logic                          right_valid,
   input  logic [swmp_pkg::SAMPLE_W-1:0] right_val,
   output logic [swmp_pkg::SAMPLE_W-1:0] val,
   output logic                          valid,
   output logic                          le,
   output logic                          gt
);
   logic [swmp_pkg::SAMPLE_W-1:0] val_ff;
   logic                          valid_ff;

   assign val = val_ff;
   assign valid = valid_ff;
   assign le = valid_ff && (val_ff <= cmd.key);
   assign gt = !valid_ff || (val_ff > cmd.key);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cmd.insert) begin
         // keep if at or below the key, else take the key or shift right
         if (!le) begin
            if (left_le) begin
               val_ff <= cmd.key;
               valid_ff <= 1'b1;
            end else begin
               val_ff <= left_val;
               valid_ff <= left_valid;
            end
         end
      end else if (cmd.remove) begin
         // close the gap of the last cell equal to the key
         if ((!valid_ff || val_ff >= cmd.key) && right_gt) begin
            val_ff <= right_val;
            valid_ff <= right_valid;
         end
      end
   end
endmodule

// ===== verif/sliding_window_mean_percentile_unit_test.sv =====
// Self-checking testbench of the sliding window mean and percentile block
module sliding_window_mean_percentile_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = swmp_pkg::WINDOW_DEPTH_DEFAULT;
   localparam int SAMPLE_W = swmp_pkg::SAMPLE_W;
   localparam int HELD_W = swmp_pkg::HELD_W;
   localparam int FRAC_W = swmp_pkg::FRAC_W;
   localparam int PADDR_W = swmp_pkg::PADDR_W;
   localparam int PDATA_W = swmp_pkg::PDATA_W;
   // Register 0 lies at byte address 0; address 4 holds no register.
   localparam logic [PADDR_W-1:0] ADDR_FRACTION =
      {{(PADDR_W-1){1'b0}}, swmp_pkg::REG_FRACTION};
   localparam logic [PADDR_W-1:0] ADDR_UNMAPPED = 3'd4;
   localparam int SETTLE_CYCLES = 60;   // more than one sample's pass through the block

   typedef struct {
      logic [SAMPLE_W-1:0] mean;
      logic [SAMPLE_W-1:0] pct;
      logic [HELD_W-1:0]   held;
   } stats_type;

   typedef struct {
      logic [SAMPLE_W-1:0] sample;
      bit                  typed;   // expected result typed in below
      stats_type           result;
   } row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                psel = 1'b0;
   logic                penable = 1'b0;
   logic                pwrite = 1'b0;
   logic [PADDR_W-1:0]  paddr = '0;
   logic [PDATA_W-1:0]  pwdata = '0;
   logic [PDATA_W-1:0]  prdata;
   logic                pready;

   swmp_req_if req_bus ();
   swmp_rsp_if rsp_bus ();

   sliding_window_mean_percentile_unit i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always #6 clock = ~clock;

   // Own copy of the window: ring, write pointer, fill level, exact total, fraction.
   logic [SAMPLE_W-1:0] ring_copy [DEPTH];
   int unsigned         wr_ptr;
   int unsigned         fill;
   logic [39:0]         total;
   logic [FRAC_W-1:0]   fraction;

   stats_type pending_stats [$];
   int        error_count = 0;
   int        beats_out = 0;

   // Interpolated order statistic of the held samples.
   function automatic logic [SAMPLE_W-1:0] window_percentile_of(int unsigned n);
      logic [SAMPLE_W-1:0] sorted [$];
      longint unsigned     idx, lo, t, a, b;
      if (fraction > swmp_pkg::Q16_ONE) return '0;
      for (int i = 0; i < n; i++) sorted.push_back(ring_copy[i]);
      sorted.sort();
      idx = longint'(fraction) * (n - 1);
      lo = idx >> 16;
      t = idx & 64'hFFFF;
      if (lo >= n) lo = n - 1;
      a = sorted[lo];
      if (t == 0 || lo + 1 >= n) return a[SAMPLE_W-1:0];
      b = sorted[lo + 1];
      return 32'((a * (65536 - t) + b * t) >> 16);
   endfunction

   // Push one sample into the window copy and return the stats it yields.
   function automatic stats_type push_sample(logic [SAMPLE_W-1:0] v);
      stats_type s;
      if (fill >= DEPTH) total -= ring_copy[wr_ptr];
      else fill++;
      ring_copy[wr_ptr] = v;
      total += v;
      wr_ptr = (wr_ptr + 1 >= DEPTH) ? 0 : wr_ptr + 1;
      s.mean = 32'(total / fill);
      s.pct = window_percentile_of(fill);
      s.held = fill[HELD_W-1:0];
      return s;
   endfunction

   // Offer one sample after gap idle cycles; hold until accepted.
   task automatic send_sample(logic [SAMPLE_W-1:0] v, int gap, bit typed, stats_type want);
      stats_type s;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.sample_value <= v;
      do @(posedge clock); while (!req_bus.ready);
      s = push_sample(v);
      pending_stats.push_back(typed ? want : s);
   endtask

   // APB write: setup cycle, then access cycle.
   task automatic csr_write(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= addr;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (addr == ADDR_FRACTION) fraction = data[FRAC_W-1:0];
   endtask

   // Back to back or short about equally often, rarely long.
   function automatic int pick_gap();
      int r = $urandom_range(99);
      if (r < 45) return 0;
      if (r < 90) return $urandom_range(1, 4);
      return $urandom_range(10, 60);
   endfunction

   function automatic logic [SAMPLE_W-1:0] pick_sample();
      int r = $urandom_range(99);
      if (r < 40) return $urandom;
      if (r < 60) return $urandom_range(1000);
      if (r < 72) return 32'hFFFF_FFFF;
      if (r < 82) return '0;
      return 32'hFFFF_FFFF - $urandom_range(1000);
   endfunction

   // Let the block drain before touching the register.
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      wait (pending_stats.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Result side: random stalls, and one long hold-off so the input backs up.
   initial begin
      rsp_bus.ready = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (beats_out == 40) begin
            rsp_bus.ready <= 1'b0;
            repeat (400) @(posedge clock);
            rsp_bus.ready <= 1'b1;
            @(posedge clock);
         end
         else if (beats_out > 150 && beats_out < 220) begin
            rsp_bus.ready <= 1'b1;   // stretch without stalls
         end
         else if ($urandom_range(99) < 4) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(10, 50)) @(posedge clock);
            rsp_bus.ready <= 1'b1;
         end
         else begin
            rsp_bus.ready <= ($urandom_range(99) < 70);
         end
      end
   end

   // Compare each result beat with the oldest expectation.
   always @(posedge clock) begin
      stats_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         beats_out <= beats_out + 1;
         if (pending_stats.size() == 0) begin
            $error("result beat with no expectation pending");
            error_count++;
         end
         else begin
            want = pending_stats.pop_front();
            if (rsp_bus.window_mean !== want.mean) begin
               $error("window_mean expected %0d actual %0d", want.mean, rsp_bus.window_mean);
               error_count++;
            end
            if (rsp_bus.window_percentile !== want.pct) begin
               $error("window_percentile expected %0d actual %0d",
                      want.pct, rsp_bus.window_percentile);
               error_count++;
            end
            if (rsp_bus.held_count !== want.held) begin
               $error("held_count expected %0d actual %0d", want.held, rsp_bus.held_count);
               error_count++;
            end
         end
      end
   end

   // Directed rows; the first three are read straight off a fresh window at 50 percent.
   row_type directed [] = '{
      '{32'h0000_0000, 1'b1, '{32'h0000_0000, 32'h0000_0000, 9'd1}},
      '{32'hFFFF_FFFF, 1'b1, '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 9'd2}},
      '{32'hFFFF_FFFF, 1'b1, '{32'hAAAA_AAAA, 32'hFFFF_FFFF, 9'd3}},
      '{32'd5, 1'b0, '{0, 0, 0}},
      '{32'd1000, 1'b0, '{0, 0, 0}},
      '{32'd7, 1'b0, '{0, 0, 0}},
      '{32'h8000_0000, 1'b0, '{0, 0, 0}},
      '{32'h7FFF_FFFF, 1'b0, '{0, 0, 0}},
      '{32'd12345678, 1'b0, '{0, 0, 0}},
      '{32'h5555_5555, 1'b0, '{0, 0, 0}},
      '{32'hAAAA_AAAA, 1'b0, '{0, 0, 0}},
      '{32'd1, 1'b0, '{0, 0, 0}},
      '{32'd1, 1'b0, '{0, 0, 0}},
      '{32'hFFFF_FFFE, 1'b0, '{0, 0, 0}},
      '{32'd3, 1'b0, '{0, 0, 0}}
   };

   // Phase fractions: 0, 1, 100%, just above, field max, 75%, 10%, just under 100%.
   logic [PDATA_W-1:0] phase_fraction [] = '{
      32'd0, 32'd1, 32'h0001_0000, 32'h0001_0001, 32'hFFFF_FFFF,
      32'd49152, 32'd6554, 32'd65535
   };

   initial begin
      stats_type none;
      none = '{0, 0, 0};
      req_bus.valid = 1'b0;
      req_bus.sample_value = '0;
      wr_ptr = 0;
      fill = 0;
      total = '0;
      fraction = swmp_pkg::FRAC_RESET;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i])
         send_sample(directed[i].sample, (i % 3 == 0) ? 0 : pick_gap(),
                     directed[i].typed, directed[i].result);

      foreach (phase_fraction[p]) begin
         wait_idle();
         csr_write(ADDR_FRACTION, phase_fraction[p]);
         if (p == 2) begin
            @(posedge clock);
            csr_write(ADDR_UNMAPPED, $urandom);   // no register there: ignored
         end
         repeat ((p == 0) ? 70 : 50)
            send_sample(pick_sample(), pick_gap(), 1'b0, none);
      end
      wait_idle();
      csr_write(ADDR_FRACTION, $urandom_range(65536));
      repeat (20) send_sample(pick_sample(), pick_gap(), 1'b0, none);

      wait_idle();
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end
      else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("CHECKS FAILED");
      $finish;
   end
endmodule

// ===== sliding_window_mean_percentile_unit.f =====
+incdir+sv
sv/swmp_pkg.sv
sv/swmp_req_if.sv
sv/swmp_rsp_if.sv
sv/swmp_cell.sv
sv/sliding_window_mean_percentile_unit.sv
verif/sliding_window_mean_percentile_unit_test.sv
